### hw/rtl/fpba_pkg.sv
// Package with the codes, field widths and defaults of the fit-policy block allocator.
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

  // Field widths of the item ports.
  localparam int CMD_W  = 2;
  localparam int BLK_W  = 5;
  localparam int SZ_W   = 16;
  localparam int STAT_W = 2;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int MODE_W     = 2;
  localparam int CNT_W      = 6;

  // Parameter defaults.
  localparam int MAX_BLOCKS_DEF = 32;
  localparam int SIZE_BITS_DEF  = 16;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_ALLOC = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd2;

  // Placement policies.
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

endpackage

`default_nettype wire

### hw/rtl/fpba_if.sv
// Channel interfaces of the allocator: request, response and configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface fpba_req_if;
  import fpba_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BLK_W-1:0]  block_index;
  logic [SZ_W-1:0]   size_value;
  modport source (output valid, command, block_index, size_value, input ready);
  modport sink   (input valid, command, block_index, size_value, output ready);
endinterface

interface fpba_rsp_if;
  import fpba_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BLK_W-1:0]  chosen_block;
  logic [SZ_W-1:0]   chosen_size;
  logic [SZ_W-1:0]   leftover;
  modport source (output valid, status, chosen_block, chosen_size, leftover, input ready);
  modport sink   (input valid, status, chosen_block, chosen_size, leftover, output ready);
endinterface

interface fpba_cfg_if;
  import fpba_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/fpba_cell.sv
// One table cell: holds a block's size and used mark and refines the search candidate.
`timescale 1ns / 1ps
`default_nettype none

module fpba_cell #(
  parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF,
  parameter int CELL_IDX   = 0
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic [fpba_pkg::MODE_W-1:0]             fit_mode,
  input  wire logic [fpba_pkg::CNT_W-1:0]              blk_count,
  input  wire logic [SIZE_BITS-1:0]                    req_size,
  input  wire logic [$clog2(MAX_BLOCKS)+SIZE_BITS+2:0] ctl,
  input  wire logic [$clog2(MAX_BLOCKS)+SIZE_BITS+1:0] cand_in,
  output logic      [$clog2(MAX_BLOCKS)+SIZE_BITS+1:0] cand_out
);
  import fpba_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);

  // Candidate record walking down the chain.
  typedef struct packed {
    logic             tok;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [SIZE_BITS-1:0] left;
  } cand_t;

  // Table control broadcast from the top level.
  typedef struct packed {
    logic             load_en;
    logic             clear;
    logic             mark_en;
    logic [IDX_W-1:0] idx;
    logic [SIZE_BITS-1:0] load_size;
  } ctl_t;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  ctl_t                 c;
  cand_t                cin;
  cand_t                cand;
  cand_t                cand_next;
  logic [SIZE_BITS-1:0] size;
  logic                 used;
  logic                 fits;
  logic                 take;
  logic [SIZE_BITS-1:0] left;

  assign c        = ctl;
  assign cin      = cand_in;
  assign cand_out = cand;

  // Table entry: size written by a load, used mark set by an allocation.
  always_ff @(posedge clk) begin
    if (c.load_en && c.idx == MY_IDX) begin
      size <= c.load_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (c.clear) begin
      used <= 1'b0;
    end else if (c.mark_en && c.idx == MY_IDX) begin
      used <= 1'b1;
    end
  end

  // Compare this entry against the candidate handed in by the previous cell.
  always_comb begin
    left = size - req_size;
    fits = cin.tok && !used && (size >= req_size) && (int'(blk_count) > CELL_IDX);
    if (!cin.found) begin
      take = fits;
    end else begin
      unique case (fit_mode)
        FIT_BEST:  take = fits && (left < cin.left);
        FIT_WORST: take = fits && (left > cin.left);
        default:   take = 1'b0;
      endcase
    end
    cand_next = cin;
    if (take) begin
      cand_next.found = 1'b1;
      cand_next.idx   = MY_IDX;
      cand_next.left  = left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand.tok <= 1'b0;
    end else begin
      cand <= cand_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fit_policy_block_allocator_core.sv
// Top level of the fit-policy block allocator: command decode, cell chain and result register.
//
//   channel  | modport | items                          | accepted when
//   ---------+---------+--------------------------------+----------------------
//   req_ch   | sink    | command, block_index, size     | valid && ready
//   rsp_ch   | source  | status, block, size, leftover  | valid && ready
//   cfg_ch   | sink    | reg_index, data                | valid && ready
//
// A load, clear or unused command answers in the cycle after it is accepted.
// An allocate walks a candidate token through the MAX_BLOCKS cells, one cell per
// cycle, and its answer is loaded into the result register as the token leaves the last cell.
// One item is in work at a time; the result register lets the next item enter
// in the cycle its result is taken. Reset clears all used marks, the
// configuration and the handshake state; block sizes hold no reset value.
`timescale 1ns / 1ps
`default_nettype none

module fit_policy_block_allocator_core #(
  parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  fpba_req_if.sink  req_ch,
  fpba_rsp_if.source rsp_ch,
  fpba_cfg_if.sink  cfg_ch
);
  import fpba_pkg::*;

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CAND_W = IDX_W + SIZE_BITS + 2;

  typedef struct packed {
    logic             tok;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [SIZE_BITS-1:0] left;
  } cand_t;

  typedef struct packed {
    logic             load_en;
    logic             clear;
    logic             mark_en;
    logic [IDX_W-1:0] idx;
    logic [SIZE_BITS-1:0] load_size;
  } ctl_t;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                  state;
  logic                  state_next;
  logic [MODE_W-1:0]     fit_mode;
  logic [CNT_W-1:0]      blk_count;
  logic [SIZE_BITS-1:0]  req_size;
  logic                  start;
  logic                  accept;
  logic                  scan_done;
  logic [SIZE_BITS-1:0]  size_in;
  ctl_t                  ctl;
  cand_t                 seed;
  cand_t                 last;
  logic [CAND_W-1:0]     chain [MAX_BLOCKS+1];

  logic                  out_valid;
  logic                  out_load;
  logic [STAT_W-1:0]     out_status;
  logic [STAT_W-1:0]     out_status_next;
  logic [BLK_W-1:0]      out_block;
  logic [BLK_W-1:0]      out_block_next;
  logic [SZ_W-1:0]       out_size;
  logic [SZ_W-1:0]       out_size_next;
  logic [SZ_W-1:0]       out_left;
  logic [SZ_W-1:0]       out_left_next;
  logic [SIZE_BITS-1:0]  chosen_sum;

  // Configuration registers; writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode  <= FIT_FIRST;
      blk_count <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        CFG_FIT_MODE:    fit_mode  <= MODE_W'(cfg_ch.data);
        CFG_BLOCK_COUNT: blk_count <= CNT_W'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // Request handshake.
  assign req_ch.ready = (state == S_IDLE) && (!out_valid || rsp_ch.ready);
  assign accept       = req_ch.valid && req_ch.ready;
  assign size_in      = SIZE_BITS'(req_ch.size_value);

  // Broadcast table control to the cells.
  assign last      = chain[MAX_BLOCKS];
  assign scan_done = (state == S_SCAN) && last.tok;

  always_comb begin
    ctl           = '0;
    ctl.load_size = size_in;
    if (accept && req_ch.command == CMD_LOAD &&
        int'(req_ch.block_index) < MAX_BLOCKS) begin
      ctl.load_en = 1'b1;
      ctl.idx     = IDX_W'(req_ch.block_index);
    end else if (accept && req_ch.command == CMD_CLEAR) begin
      ctl.clear = 1'b1;
    end else if (scan_done && last.found) begin
      ctl.mark_en = 1'b1;
      ctl.idx     = last.idx;
    end
  end

  // Sequencer: idle, or waiting for the token to leave the last cell.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && req_ch.command == CMD_ALLOC) state_next = S_SCAN;
      S_SCAN: if (scan_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start <= 1'b0;
    end else begin
      state <= state_next;
      start <= accept && req_ch.command == CMD_ALLOC;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_size <= size_in;
    end
  end

  // Cell chain; the first cell sees a fresh token in the cycle after the request.
  always_comb begin
    seed     = '0;
    seed.tok = start;
  end
  assign chain[0] = seed;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    fpba_cell #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .SIZE_BITS  (SIZE_BITS),
      .CELL_IDX   (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .fit_mode  (fit_mode),
      .blk_count (blk_count),
      .req_size  (req_size),
      .ctl       (ctl),
      .cand_in   (chain[g]),
      .cand_out  (chain[g+1])
    );
  end

  // Result selection.
  assign chosen_sum = last.left + req_size;

  always_comb begin
    out_load        = 1'b0;
    out_status_next = ST_DONE;
    out_block_next  = '0;
    out_size_next   = '0;
    out_left_next   = '0;
    if (accept && req_ch.command != CMD_ALLOC) begin
      out_load = 1'b1;
    end else if (scan_done) begin
      out_load = 1'b1;
      if (last.found) begin
        out_status_next = ST_ALLOC;
        out_block_next  = BLK_W'(last.idx);
        out_size_next   = SZ_W'(chosen_sum);
        out_left_next   = SZ_W'(last.left);
      end else begin
        out_status_next = ST_NOFIT;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= out_status_next;
      out_block  <= out_block_next;
      out_size   <= out_size_next;
      out_left   <= out_left_next;
    end
  end

  assign rsp_ch.valid        = out_valid;
  assign rsp_ch.status       = out_status;
  assign rsp_ch.chosen_block = out_block;
  assign rsp_ch.chosen_size  = out_size;
  assign rsp_ch.leftover     = out_left;

endmodule

`default_nettype wire

### hw/rtl/fpba_checker.sv
// Port-level checks of the allocator and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fpba_port_checks (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [fpba_pkg::CMD_W-1:0]    in_command,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [fpba_pkg::STAT_W-1:0]   out_status,
  input wire logic [fpba_pkg::BLK_W-1:0]    out_block,
  input wire logic [fpba_pkg::SZ_W-1:0]     out_size,
  input wire logic [fpba_pkg::SZ_W-1:0]     out_left
);
  import fpba_pkg::*;

  // An allocate occupies the block, so no item enters in the next cycle.
  a_alloc_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_command == CMD_ALLOC |=> !in_ready)
    else $error("request taken right after an allocate");

  // Results other than an allocation carry zero payload.
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_ALLOC |->
      out_block == '0 && out_size == '0 && out_left == '0)
    else $error("non-allocation result with nonzero payload");

  // A leftover never exceeds the allocated size.
  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_ALLOC |-> out_left <= out_size)
    else $error("leftover larger than block size");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(out_status) && $stable(out_block) &&
      $stable(out_size) && $stable(out_left))
    else $error("stalled result changed");

endmodule

bind fit_policy_block_allocator_core fpba_port_checks u_fpba_port_checks (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req_ch.valid),
  .in_ready   (req_ch.ready),
  .in_command (req_ch.command),
  .out_valid  (rsp_ch.valid),
  .out_ready  (rsp_ch.ready),
  .out_status (rsp_ch.status),
  .out_block  (rsp_ch.chosen_block),
  .out_size   (rsp_ch.chosen_size),
  .out_left   (rsp_ch.leftover)
);

`default_nettype wire
